// ===== rtl/ljc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the LJ/Coulomb pair force core.
// Holds the internal floating format (32-bit mantissa, signed exponent) and its ops.
// No dependencies.
package ljc_pkg;

    localparam int EXP_W    = 12;
    localparam int DIV_LAT  = 32;
    localparam int SQRT_LAT = 32;

    localparam logic [31:0] SCALE_RST = 32'd21762127;

    typedef enum logic {
        REG_SCALE  = 1'b0,
        REG_ENERGY = 1'b1
    } t_reg_idx;

    // value = (-1)^neg * m * 2^e, m has bit 31 set or is zero
    typedef struct packed {
        logic                    neg;
        logic [31:0]             m;
        logic signed [EXP_W-1:0] e;
    } t_pf;

    // unnormalized: (-1)^neg * mag * 2^e
    typedef struct packed {
        logic                    neg;
        logic [63:0]             mag;
        logic signed [EXP_W-1:0] e;
    } t_raw;

    localparam t_pf K_TWELFTH = '{neg: 1'b0, m: 32'hAAAA_AAAA, e: EXP_W'(-35)};
    localparam t_pf K_SIXTH   = '{neg: 1'b0, m: 32'hAAAA_AAAA, e: EXP_W'(-34)};

    function automatic t_raw f_sraw(input logic [63:0] v, input logic signed [EXP_W-1:0] e);
        t_raw r;
        r.neg = v[63];
        r.mag = v[63] ? (64'd0 - v) : v;
        r.e   = e;
        return r;
    endfunction

    // truncate to 32 significant bits
    function automatic t_pf f_norm(input t_raw a);
        t_pf         r;
        int          p;
        logic [63:0] sh;
        r = '0;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (a.mag[i]) p = i;
        end
        if (a.mag != 64'd0) begin
            sh    = a.mag << (63 - p);
            r.neg = a.neg;
            r.m   = sh[63:32];
            r.e   = a.e + EXP_W'(p - 31);
        end
        return r;
    endfunction

    function automatic t_pf f_mul(input t_pf a, input t_pf b);
        t_pf                     r;
        logic [63:0]             pr;
        logic signed [EXP_W-1:0] es;
        r  = '0;
        pr = {32'd0, a.m} * {32'd0, b.m};
        es = a.e + b.e;
        if (a.m != 32'd0 && b.m != 32'd0) begin
            r.neg = a.neg ^ b.neg;
            if (pr[63]) begin
                r.m = pr[63:32];
                r.e = es + EXP_W'(32);
            end else begin
                r.m = pr[62:31];
                r.e = es + EXP_W'(31);
            end
        end
        return r;
    endfunction

    function automatic t_pf f_neg(input t_pf a);
        t_pf r;
        r = a;
        if (a.m != 32'd0) r.neg = ~a.neg;
        return r;
    endfunction

    // align and add; f_norm finishes the sum in the next stage
    function automatic t_raw f_add_pre(input t_pf a, input t_pf b);
        t_raw          r;
        t_pf           x;
        t_pf           y;
        logic [EXP_W:0] d;
        logic [63:0]   xm;
        logic [63:0]   ym;
        if (b.e > a.e || (b.e == a.e && b.m > a.m)) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        d  = {x.e[EXP_W-1], x.e} - {y.e[EXP_W-1], y.e};
        xm = {1'b0, x.m, 31'd0};
        ym = (d > (EXP_W+1)'(62)) ? 64'd0 : ({1'b0, y.m, 31'd0} >> d);
        r.neg = x.neg;
        r.mag = (x.neg == y.neg) ? (xm + ym) : (xm - ym);
        r.e   = x.e - EXP_W'(31);
        if (a.m == 32'd0) begin
            r.neg = b.neg;
            r.mag = {1'b0, b.m, 31'd0};
            r.e   = b.e - EXP_W'(31);
        end else if (b.m == 32'd0) begin
            r.neg = a.neg;
            r.mag = {1'b0, a.m, 31'd0};
            r.e   = a.e - EXP_W'(31);
        end
        return r;
    endfunction

    // to Q32.16, truncated toward zero, saturated
    function automatic logic [47:0] f_to_q16(input t_pf a);
        logic signed [EXP_W:0] sh;
        logic [63:0]           mag;
        logic [47:0]           r;
        sh  = {a.e[EXP_W-1], a.e} + (EXP_W+1)'(16);
        mag = '0;
        if (a.m == 32'd0 || sh <= -(EXP_W+1)'(32)) begin
            r = '0;
        end else if (sh >= (EXP_W+1)'(16)) begin
            r = a.neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end else begin
            if (sh < 0) mag = {32'd0, a.m} >> (-sh);
            else        mag = {32'd0, a.m} << sh;
            if (a.neg) mag = 64'd0 - mag;
            r = mag[47:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ljc_recip.sv =====
// Pipelined reciprocal floor(2^63 / m), one quotient bit per stage.
// Depends on ljc_pkg.
module ljc_recip
    import ljc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pf  i_a,
    output logic o_valid,
    output t_pf  o_r
);

    typedef struct packed {
        logic [31:0]             m;
        logic [31:0]             rem;
        logic [31:0]             q;
        logic                    neg;
        logic signed [EXP_W-1:0] e;
        logic                    sp;
    } t_dst;

    function automatic t_dst f_step(input t_dst s);
        t_dst        r;
        logic [32:0] rem2;
        r    = s;
        rem2 = {s.rem, 1'b0};
        if (rem2 >= {1'b0, s.m}) begin
            r.rem = 32'(rem2 - {1'b0, s.m});
            r.q   = {s.q[30:0], 1'b1};
        end else begin
            r.rem = rem2[31:0];
            r.q   = {s.q[30:0], 1'b0};
        end
        return r;
    endfunction

    t_dst                 r_st [DIV_LAT];
    t_dst                 n_st [DIV_LAT];
    t_dst                 w_init;
    logic [DIV_LAT-1:0]   r_v;

    always_comb begin
        w_init.m   = i_a.m;
        w_init.rem = 32'h8000_0000;  // top half of 2^63
        w_init.q   = '0;
        w_init.neg = i_a.neg;
        w_init.e   = i_a.e;
        w_init.sp  = (i_a.m == 32'h8000_0000);
        n_st[0]    = f_step(w_init);
        for (int k = 1; k < DIV_LAT; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_LAT-2:0], i_valid};
        end
    end

    // an exact power of two has a quotient one bit too wide
    always_comb begin
        o_r.neg = r_st[DIV_LAT-1].neg;
        if (r_st[DIV_LAT-1].sp) begin
            o_r.m = 32'h8000_0000;
            o_r.e = EXP_W'(-62) - r_st[DIV_LAT-1].e;
        end else begin
            o_r.m = r_st[DIV_LAT-1].q;
            o_r.e = EXP_W'(-63) - r_st[DIV_LAT-1].e;
        end
    end

    assign o_valid = r_v[DIV_LAT-1];

    a_quot_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[DIV_LAT-1] |-> (r_st[DIV_LAT-1].sp || r_st[DIV_LAT-1].q[31]))
        else $error("reciprocal quotient not normalized");

endmodule

// ===== rtl/ljc_sqrt.sv =====
// Pipelined square root of a positive value, one root bit per stage.
// Depends on ljc_pkg.
module ljc_sqrt
    import ljc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_pf  i_a,
    output logic o_valid,
    output t_pf  o_r
);

    typedef struct packed {
        logic [63:0]             n;
        logic [33:0]             rem;
        logic [31:0]             root;
        logic signed [EXP_W-1:0] e;
    } t_sst;

    function automatic t_sst f_step(input t_sst s);
        t_sst        r;
        logic [35:0] t;
        logic [35:0] tst;
        r   = s;
        t   = {s.rem, s.n[63:62]};
        tst = {2'b00, s.root, 2'b01};
        r.n = {s.n[61:0], 2'b00};
        if (t >= tst) begin
            r.rem  = 34'(t - tst);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = t[33:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    t_sst                  r_st [SQRT_LAT];
    t_sst                  n_st [SQRT_LAT];
    t_sst                  w_init;
    logic signed [EXP_W-1:0] w_eadj;
    logic [SQRT_LAT-1:0]   r_v;

    always_comb begin
        // make the exponent even, then halve it
        if (!i_a.e[0]) begin
            w_init.n = {i_a.m, 32'd0};
            w_eadj   = i_a.e - EXP_W'(32);
        end else begin
            w_init.n = {1'b0, i_a.m, 31'd0};
            w_eadj   = i_a.e - EXP_W'(31);
        end
        w_init.rem  = '0;
        w_init.root = '0;
        w_init.e    = w_eadj >>> 1;
        n_st[0]     = f_step(w_init);
        for (int k = 1; k < SQRT_LAT; k++) begin
            n_st[k] = f_step(r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_LAT; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQRT_LAT-2:0], i_valid};
        end
    end

    assign o_r.neg = 1'b0;
    assign o_r.m   = r_st[SQRT_LAT-1].root;
    assign o_r.e   = r_st[SQRT_LAT-1].e;
    assign o_valid = r_v[SQRT_LAT-1];

    a_root_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[SQRT_LAT-1] |-> r_st[SQRT_LAT-1].root[31])
        else $error("square root result not normalized");

endmodule

// ===== rtl/lj_coulomb_pair_force_core.sv =====
// Top level of the LJ 12-6 plus Coulomb pair force core: pipeline, APB registers.
// Depends on ljc_pkg, ljc_recip and ljc_sqrt.
//
// Accepts one atom pair per clock while the output is not stalled. A pair passes the
// input register, six stages to form |d|^2, 32 reciprocal stages and 32 square root
// stages (one result bit each), eleven stages of products and sums, and the output
// register. A stalled output freezes the whole pipeline; nothing is dropped.
// Forces are on atom i and weighted; pair_energy is unweighted and zero unless
// energy_enable is set. Coincident atoms give zero outputs with zero_distance set.
// Change the registers only while no pair is in flight.
module lj_coulomb_pair_force_core
    import ljc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_pos_i_x,
    input  logic signed [31:0] i_pos_i_y,
    input  logic signed [31:0] i_pos_i_z,
    input  logic signed [31:0] i_pos_j_x,
    input  logic signed [31:0] i_pos_j_y,
    input  logic signed [31:0] i_pos_j_z,
    input  logic signed [15:0] i_charge_i,
    input  logic signed [15:0] i_charge_j,
    input  logic [15:0]        i_weight_i,
    input  logic [15:0]        i_weight_j,
    input  logic signed [47:0] i_lj_repulsive,
    input  logic signed [47:0] i_lj_attractive,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_force_x,
    output logic signed [47:0] o_force_y,
    output logic signed [47:0] o_force_z,
    output logic signed [47:0] o_pair_energy,
    output logic               o_zero_distance
);

    localparam int NF = 6;
    localparam int NT = 11;

    typedef struct packed {
        logic signed [32:0] dv0;
        logic signed [32:0] dv1;
        logic signed [32:0] dv2;
        logic               zero;
        logic [47:0]        ca;
        logic [47:0]        cb;
        logic [15:0]        qi;
        logic [15:0]        qj;
        logic [31:0]        wprod;
    } t_front;

    typedef struct packed {
        logic zero;
        t_pf  d0;
        t_pf  d1;
        t_pf  d2;
        t_pf  ca;
        t_pf  cb;
        t_pf  w;
        t_pf  coul;
        t_pf  qj;
        t_pf  p0;
        t_pf  p1;
        t_pf  p2;
        t_pf  r2;
        t_pf  r6;
        t_pf  e12;
        t_pf  e6;
        t_raw x0;
        t_raw x1;
    } t_ctx;

    logic [31:0] r_scale;
    logic        r_energy_en;
    logic        w_en;

    t_front      r_s1;
    logic        r_v1;
    t_ctx        r_fc [NF];
    t_ctx        n_fc [NF];
    logic [NF-1:0] r_fv;
    t_ctx        r_dc [DIV_LAT];
    t_ctx        r_ec [SQRT_LAT];
    t_ctx        n_ec0;
    t_ctx        r_tc [NT];
    t_ctx        n_tc [NT];
    logic [NT-1:0] r_tv;
    logic        r_ov;

    logic [47:0] r_force_x;
    logic [47:0] r_force_y;
    logic [47:0] r_force_z;
    logic [47:0] r_energy;
    logic        r_zero;

    logic        w_rcp_v;
    t_pf         w_r2inv;
    logic        w_sq_v;
    t_pf         w_rinv;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RST;
            r_energy_en <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_SCALE:  r_scale     <= pwdata;
                REG_ENERGY: r_energy_en <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_SCALE:  prdata = r_scale;
            REG_ENERGY: prdata = {31'd0, r_energy_en};
        endcase
    end

    // ---------------- flow control ----------------
    assign w_en        = !r_ov || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_ov;

    // ---------------- front: |d|^2 ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.dv0   <= {i_pos_i_x[31], i_pos_i_x} - {i_pos_j_x[31], i_pos_j_x};
            r_s1.dv1   <= {i_pos_i_y[31], i_pos_i_y} - {i_pos_j_y[31], i_pos_j_y};
            r_s1.dv2   <= {i_pos_i_z[31], i_pos_i_z} - {i_pos_j_z[31], i_pos_j_z};
            r_s1.zero  <= (i_pos_i_x == i_pos_j_x) && (i_pos_i_y == i_pos_j_y)
                          && (i_pos_i_z == i_pos_j_z);
            r_s1.ca    <= i_lj_repulsive;
            r_s1.cb    <= i_lj_attractive;
            r_s1.qi    <= i_charge_i;
            r_s1.qj    <= i_charge_j;
            r_s1.wprod <= {16'd0, i_weight_i} * {16'd0, i_weight_j};
        end
    end

    always_comb begin
        n_fc[0]      = '0;
        n_fc[0].zero = r_s1.zero;
        n_fc[0].d0   = f_norm(f_sraw({{31{r_s1.dv0[32]}}, r_s1.dv0}, EXP_W'(-16)));
        n_fc[0].d1   = f_norm(f_sraw({{31{r_s1.dv1[32]}}, r_s1.dv1}, EXP_W'(-16)));
        n_fc[0].d2   = f_norm(f_sraw({{31{r_s1.dv2[32]}}, r_s1.dv2}, EXP_W'(-16)));
        n_fc[0].ca   = f_norm(f_sraw({{16{r_s1.ca[47]}}, r_s1.ca}, EXP_W'(-16)));
        n_fc[0].cb   = f_norm(f_sraw({{16{r_s1.cb[47]}}, r_s1.cb}, EXP_W'(-16)));
        n_fc[0].p0   = f_norm(f_sraw({{48{r_s1.qi[15]}}, r_s1.qi}, EXP_W'(-12)));
        n_fc[0].qj   = f_norm(f_sraw({{48{r_s1.qj[15]}}, r_s1.qj}, EXP_W'(-12)));
        n_fc[0].w    = f_norm('{neg: 1'b0, mag: {32'd0, r_s1.wprod}, e: EXP_W'(-30)});
        n_fc[0].p1   = f_norm('{neg: 1'b0, mag: {32'd0, r_scale}, e: EXP_W'(-16)});

        n_fc[1]      = r_fc[0];
        n_fc[1].coul = f_mul(r_fc[0].p1, r_fc[0].p0);
        n_fc[1].p0   = f_mul(r_fc[0].d0, r_fc[0].d0);
        n_fc[1].p1   = f_mul(r_fc[0].d1, r_fc[0].d1);
        n_fc[1].p2   = f_mul(r_fc[0].d2, r_fc[0].d2);

        n_fc[2]      = r_fc[1];
        n_fc[2].x0   = f_add_pre(r_fc[1].p0, r_fc[1].p1);
        n_fc[2].coul = f_mul(r_fc[1].coul, r_fc[1].qj);

        n_fc[3]      = r_fc[2];
        n_fc[3].p0   = f_norm(r_fc[2].x0);

        n_fc[4]      = r_fc[3];
        n_fc[4].x0   = f_add_pre(r_fc[3].p0, r_fc[3].p2);

        n_fc[5]      = r_fc[4];
        n_fc[5].p0   = f_norm(r_fc[4].x0);   // r^2
    end

    // ---------------- 1/r^2 and 1/r ----------------
    ljc_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_fv[NF-1]),
        .i_a     (r_fc[NF-1].p0),
        .o_valid (w_rcp_v),
        .o_r     (w_r2inv)
    );

    ljc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rcp_v),
        .i_a     (w_r2inv),
        .o_valid (w_sq_v),
        .o_r     (w_rinv)
    );

    always_comb begin
        n_ec0    = r_dc[DIV_LAT-1];
        n_ec0.r2 = w_r2inv;
    end

    // ---------------- tail: force and energy ----------------
    always_comb begin
        n_tc[0]      = r_ec[SQRT_LAT-1];
        n_tc[0].coul = f_mul(r_ec[SQRT_LAT-1].coul, w_rinv);
        n_tc[0].p0   = f_mul(r_ec[SQRT_LAT-1].r2, r_ec[SQRT_LAT-1].r2);

        n_tc[1]      = r_tc[0];
        n_tc[1].r6   = f_mul(r_tc[0].p0, r_tc[0].r2);

        n_tc[2]      = r_tc[1];
        n_tc[2].p0   = f_mul(r_tc[1].ca, r_tc[1].r6);
        n_tc[2].e12  = f_mul(r_tc[1].ca, K_TWELFTH);
        n_tc[2].e6   = f_mul(r_tc[1].cb, K_SIXTH);

        n_tc[3]      = r_tc[2];
        n_tc[3].x0   = f_add_pre(r_tc[2].p0, f_neg(r_tc[2].cb));
        n_tc[3].p1   = f_mul(r_tc[2].e12, r_tc[2].r6);

        n_tc[4]      = r_tc[3];
        n_tc[4].p0   = f_norm(r_tc[3].x0);
        n_tc[4].x1   = f_add_pre(r_tc[3].p1, f_neg(r_tc[3].e6));

        n_tc[5]      = r_tc[4];
        n_tc[5].p0   = f_mul(r_tc[4].r6, r_tc[4].p0);   // LJ force term
        n_tc[5].p1   = f_norm(r_tc[4].x1);

        n_tc[6]      = r_tc[5];
        n_tc[6].x0   = f_add_pre(r_tc[5].p0, r_tc[5].coul);
        n_tc[6].p1   = f_mul(r_tc[5].r6, r_tc[5].p1);

        n_tc[7]      = r_tc[6];
        n_tc[7].p0   = f_norm(r_tc[6].x0);
        n_tc[7].x1   = f_add_pre(r_tc[6].p1, r_tc[6].coul);

        n_tc[8]      = r_tc[7];
        n_tc[8].p0   = f_mul(r_tc[7].p0, r_tc[7].r2);
        n_tc[8].p1   = f_norm(r_tc[7].x1);              // pair energy

        n_tc[9]      = r_tc[8];
        n_tc[9].p0   = f_mul(r_tc[8].p0, r_tc[8].w);    // fpair

        n_tc[10]     = r_tc[9];
        n_tc[10].d0  = f_mul(r_tc[9].p0, r_tc[9].d0);
        n_tc[10].d1  = f_mul(r_tc[9].p0, r_tc[9].d1);
        n_tc[10].d2  = f_mul(r_tc[9].p0, r_tc[9].d2);
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NF; k++) begin
                r_fc[k] <= n_fc[k];
            end
            r_dc[0] <= r_fc[NF-1];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dc[k] <= r_dc[k-1];
            end
            r_ec[0] <= n_ec0;
            for (int k = 1; k < SQRT_LAT; k++) begin
                r_ec[k] <= r_ec[k-1];
            end
            for (int k = 0; k < NT; k++) begin
                r_tc[k] <= n_tc[k];
            end
            r_zero <= r_tc[NT-1].zero;
            if (r_tc[NT-1].zero) begin
                r_force_x <= '0;
                r_force_y <= '0;
                r_force_z <= '0;
                r_energy  <= '0;
            end else begin
                r_force_x <= f_to_q16(r_tc[NT-1].d0);
                r_force_y <= f_to_q16(r_tc[NT-1].d1);
                r_force_z <= f_to_q16(r_tc[NT-1].d2);
                r_energy  <= r_energy_en ? f_to_q16(r_tc[NT-1].p1) : 48'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_fv <= '0;
            r_tv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
            r_fv <= {r_fv[NF-2:0], r_v1};
            r_tv <= {r_tv[NT-2:0], w_sq_v};
            r_ov <= r_tv[NT-1];
        end
    end

    assign o_force_x       = r_force_x;
    assign o_force_y       = r_force_y;
    assign o_force_z       = r_force_z;
    assign o_pair_energy   = r_energy;
    assign o_zero_distance = r_zero;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_zero) |-> (r_force_x == '0 && r_force_y == '0 && r_force_z == '0
                              && r_energy == '0))
        else $error("zero distance beat carries nonzero outputs");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_fv) && $stable(r_tv) && $stable(r_v1)))
        else $error("pipeline valid bits moved during a stall");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |=> (r_ov && $stable(r_force_x) && $stable(r_force_y)
                                    && $stable(r_force_z) && $stable(r_energy)
                                    && $stable(r_zero)))
        else $error("result beat changed while waiting");

endmodule

// ===== dv/ljc_pair_checker.sv =====
// Checker for lj_coulomb_pair_force_core: snoops the APB writes and both beat channels,
// predicts each pair result in its own floating format and compares it field by field.
// Depends only on the block's port list.
`timescale 1ns / 100ps

module ljc_pair_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic signed [31:0] i_pos_i_x,
    input  logic signed [31:0] i_pos_i_y,
    input  logic signed [31:0] i_pos_i_z,
    input  logic signed [31:0] i_pos_j_x,
    input  logic signed [31:0] i_pos_j_y,
    input  logic signed [31:0] i_pos_j_z,
    input  logic signed [15:0] i_charge_i,
    input  logic signed [15:0] i_charge_j,
    input  logic [15:0]        i_weight_i,
    input  logic [15:0]        i_weight_j,
    input  logic signed [47:0] i_lj_repulsive,
    input  logic signed [47:0] i_lj_attractive,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [47:0]        i_force_x,
    input  logic [47:0]        i_force_y,
    input  logic [47:0]        i_force_z,
    input  logic [47:0]        i_pair_energy,
    input  logic               i_zero_distance,
    output int                 o_fail_cnt,
    output int                 o_pending
);

    localparam logic [31:0] SCALE_AT_RESET = 32'd21762127;
    localparam logic ADDR_SCALE  = 1'b0;
    localparam logic ADDR_ENERGY = 1'b1;

    // (-1)^neg * m * 2^e, m normalized to bit 31 or zero
    typedef struct {
        bit      neg;
        bit [31:0] m;
        int      e;
    } fnum_t;

    typedef struct {
        bit [47:0] fx;
        bit [47:0] fy;
        bit [47:0] fz;
        bit [47:0] energy;
        bit        zero_dist;
    } force_res_t;

    force_res_t force_q[$];
    bit [31:0]  coul_scale;
    bit         energy_on;

    function automatic fnum_t fn_make(bit neg, bit [63:0] mag, int frac);
        fnum_t r;
        int    p;
        r = '{0, 0, 0};
        if (mag == 0) return r;
        p = 63;
        while (!mag[p]) p--;
        r.m   = (p >= 31) ? 32'(mag >> (p - 31)) : 32'(mag << (31 - p));
        r.e   = p - 31 - frac;
        r.neg = neg;
        return r;
    endfunction

    function automatic fnum_t fn_signed(longint v, int frac);
        return (v < 0) ? fn_make(1, 64'(-v), frac) : fn_make(0, 64'(v), frac);
    endfunction

    function automatic fnum_t fn_neg(fnum_t a);
        if (a.m != 0) a.neg = ~a.neg;
        return a;
    endfunction

    function automatic fnum_t fn_mul(fnum_t a, fnum_t b);
        bit [63:0] pr;
        pr = {32'd0, a.m} * {32'd0, b.m};
        if (a.m == 0 || b.m == 0) return fn_make(0, 0, 0);
        return fn_make(a.neg ^ b.neg, pr, -(a.e + b.e));
    endfunction

    function automatic fnum_t fn_add(fnum_t a, fnum_t b);
        fnum_t     t;
        int        d;
        bit [63:0] x, y, s;
        if (a.m == 0) return b;
        if (b.m == 0) return a;
        if (b.e > a.e || (b.e == a.e && b.m > a.m)) begin
            t = a; a = b; b = t;
        end
        d = a.e - b.e;
        x = {32'd0, a.m} << 31;
        y = (d > 62) ? 64'd0 : (({32'd0, b.m} << 31) >> d);
        s = (a.neg == b.neg) ? x + y : x - y;
        return fn_make(a.neg, s, 31 - a.e);
    endfunction

    function automatic fnum_t fn_recip(fnum_t a);
        fnum_t r;
        if (a.m == 0) return fn_make(0, 0, 0);
        if (a.m == 32'h8000_0000) begin
            r = '{a.neg, 32'h8000_0000, -62 - a.e};
            return r;
        end
        return fn_make(a.neg, (64'd1 << 63) / {32'd0, a.m}, 63 + a.e);
    endfunction

    function automatic bit [63:0] int_root(bit [63:0] n);
        bit [63:0] res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic fnum_t fn_sqrt(fnum_t a);
        bit [31:0] ev;
        ev = a.e;
        if (a.m == 0 || a.neg) return fn_make(0, 0, 0);
        if (!ev[0]) return fn_make(0, int_root({32'd0, a.m} << 32), (32 - a.e) / 2);
        return fn_make(0, int_root({32'd0, a.m} << 31), (31 - a.e) / 2);
    endfunction

    function automatic bit [47:0] fn_to_q16(fnum_t a);
        int        sh;
        bit [63:0] mag;
        if (a.m == 0) return 48'd0;
        sh = a.e + 16;
        if (sh >= 16) return a.neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        if (sh <= -32) return 48'd0;
        mag = (sh < 0) ? ({32'd0, a.m} >> (-sh)) : ({32'd0, a.m} << sh);
        if (a.neg) mag = -mag;
        return mag[47:0];
    endfunction

    function automatic force_res_t pair_force();
        force_res_t r;
        longint     dv[3];
        fnum_t      d[3], rsq, r2inv, rinv, r6inv, ca, cb, lj, coul, w, fp, en;
        dv[0] = longint'(i_pos_i_x) - longint'(i_pos_j_x);
        dv[1] = longint'(i_pos_i_y) - longint'(i_pos_j_y);
        dv[2] = longint'(i_pos_i_z) - longint'(i_pos_j_z);
        r = '{0, 0, 0, 0, 0};
        if (dv[0] == 0 && dv[1] == 0 && dv[2] == 0) begin
            r.zero_dist = 1;
            return r;
        end
        for (int k = 0; k < 3; k++) d[k] = fn_signed(dv[k], 16);
        rsq = fn_add(fn_add(fn_mul(d[0], d[0]), fn_mul(d[1], d[1])), fn_mul(d[2], d[2]));
        r2inv = fn_recip(rsq);
        rinv  = fn_sqrt(r2inv);
        r6inv = fn_mul(fn_mul(r2inv, r2inv), r2inv);
        ca = fn_signed(longint'(i_lj_repulsive), 16);
        cb = fn_signed(longint'(i_lj_attractive), 16);
        lj = fn_mul(r6inv, fn_add(fn_mul(ca, r6inv), fn_neg(cb)));
        coul = fn_make(0, {32'd0, coul_scale}, 16);
        coul = fn_mul(coul, fn_signed(longint'(i_charge_i), 12));
        coul = fn_mul(coul, fn_signed(longint'(i_charge_j), 12));
        coul = fn_mul(coul, rinv);
        w  = fn_make(0, {48'd0, i_weight_i} * {48'd0, i_weight_j}, 30);
        fp = fn_mul(fn_mul(fn_add(lj, coul), r2inv), w);
        r.fx = fn_to_q16(fn_mul(fp, d[0]));
        r.fy = fn_to_q16(fn_mul(fp, d[1]));
        r.fz = fn_to_q16(fn_mul(fp, d[2]));
        if (energy_on) begin
            // 1/12 and 1/6 kept to 32 significant bits
            en = fn_add(fn_mul(fn_mul(ca, '{0, 32'hAAAA_AAAA, -35}), r6inv),
                        fn_neg(fn_mul(cb, '{0, 32'hAAAA_AAAA, -34})));
            en = fn_add(fn_mul(r6inv, en), coul);
            r.energy = fn_to_q16(en);
        end
        return r;
    endfunction

    task automatic cmp_field(string name, bit [47:0] exp_v, bit [47:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    assign o_pending = force_q.size();

    always @(posedge i_clk) begin
        force_res_t ex;
        if (!i_rst_n) begin
            coul_scale = SCALE_AT_RESET;
            energy_on  = 0;
            o_fail_cnt = 0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == ADDR_SCALE) coul_scale = pwdata;
                else if (paddr[2] == ADDR_ENERGY) energy_on = pwdata[0];
            end
            if (i_in_valid && i_in_ready) force_q.push_back(pair_force());
            if (i_out_valid && i_out_ready) begin
                if (force_q.size() == 0) begin
                    $error("result beat with no pair outstanding");
                    o_fail_cnt++;
                end else begin
                    ex = force_q.pop_front();
                    cmp_field("force_x", ex.fx, i_force_x);
                    cmp_field("force_y", ex.fy, i_force_y);
                    cmp_field("force_z", ex.fz, i_force_z);
                    cmp_field("pair_energy", ex.energy, i_pair_energy);
                    cmp_field("zero_distance", 48'(ex.zero_dist), 48'(i_zero_distance));
                end
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for lj_coulomb_pair_force_core: clock, reset, APB setup, pair stimulus
// with bursty input and stalling output, watchdog and verdict. Uses ljc_pair_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [2:0] ADDR_SCALE  = 3'd0;
    localparam logic [2:0] ADDR_ENERGY = 3'd4;
    localparam int         PIPE_LAT    = 83;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         RAND_PER_PH = 345;

    typedef struct {
        logic signed [31:0] pix, piy, piz, pjx, pjy, pjz;
        logic signed [15:0] qi, qj;
        logic [15:0]        wi, wj;
        logic signed [47:0] rep, att;
    } pair_t;

    logic               i_clk, i_rst_n;
    logic               psel, penable, pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    logic               i_in_valid, o_in_ready;
    logic signed [31:0] i_pos_i_x, i_pos_i_y, i_pos_i_z, i_pos_j_x, i_pos_j_y, i_pos_j_z;
    logic signed [15:0] i_charge_i, i_charge_j;
    logic [15:0]        i_weight_i, i_weight_j;
    logic signed [47:0] i_lj_repulsive, i_lj_attractive;
    logic               o_out_valid, i_out_ready;
    logic signed [47:0] o_force_x, o_force_y, o_force_z, o_pair_energy;
    logic               o_zero_distance;
    int                 fail_cnt, pending, hold_off, idle_cycles;

    lj_coulomb_pair_force_core dut (.*);

    ljc_pair_checker u_chk (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_pos_i_x, .i_pos_i_y, .i_pos_i_z, .i_pos_j_x, .i_pos_j_y, .i_pos_j_z,
        .i_charge_i, .i_charge_j, .i_weight_i, .i_weight_j,
        .i_lj_repulsive, .i_lj_attractive,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_force_x(o_force_x), .i_force_y(o_force_y), .i_force_z(o_force_z),
        .i_pair_energy(o_pair_energy), .i_zero_distance(o_zero_distance),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: stall pattern changes at random times, long hold-off on request
    initial begin
        int mode;
        i_out_ready = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(63) == 0) mode = $urandom_range(3);
            if (hold_off > 0) begin
                hold_off--;
                i_out_ready = 0;
            end else begin
                case (mode)
                    0: i_out_ready = 1;
                    1: i_out_ready = ($urandom_range(1) == 0);
                    2: i_out_ready = ($urandom_range(9) != 0);
                    default: i_out_ready = ($urandom_range(4) == 0);
                endcase
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel = 1; pwrite = 1; paddr = addr; pwdata = data; penable = 0;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    int burst_left;

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_pair(pair_t p);
        if (burst_left == 0) begin
            i_in_valid = 0;
            repeat ($urandom_range(6)) @(negedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(80, 20) : $urandom_range(8, 1);
        end
        burst_left--;
        i_in_valid = 1;
        i_pos_i_x = p.pix; i_pos_i_y = p.piy; i_pos_i_z = p.piz;
        i_pos_j_x = p.pjx; i_pos_j_y = p.pjy; i_pos_j_z = p.pjz;
        i_charge_i = p.qi; i_charge_j = p.qj; i_weight_i = p.wi; i_weight_j = p.wj;
        i_lj_repulsive = p.rep; i_lj_attractive = p.att;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom, $urandom} >> $urandom_range(47));
    endfunction

    function automatic pair_t rnd_pair();
        pair_t p;
        int    sh;
        p.pix = $urandom; p.piy = $urandom; p.piz = $urandom;
        p.qi = 16'($urandom); p.qj = 16'($urandom);
        p.wi = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        p.wj = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
        p.rep = rnd48(); p.att = rnd48();
        case ($urandom_range(9))
            0: begin
                p.pjx = $urandom; p.pjy = $urandom; p.pjz = $urandom;
            end
            1: begin
                p.pjx = p.pix; p.pjy = p.piy; p.pjz = p.piz;
            end
            default: begin
                // near neighbours: offsets per axis of up to 2^29 LSB, or up to 2^11 LSB at the narrowest
                sh = $urandom_range(20, 2);
                p.pjx = p.pix + (int'($urandom) >>> sh);
                p.pjy = p.piy + (int'($urandom) >>> sh);
                p.pjz = p.piz + (int'($urandom) >>> sh);
            end
        endcase
        return p;
    endfunction

    task automatic directed_pairs();
        pair_t p;
        p = rnd_pair();
        p.pjx = p.pix; p.pjy = p.piy; p.pjz = p.piz;
        send_pair(p);                                   // coincident atoms
        p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              16'sh7FFF, 16'sh7FFF, 16'd32768, 16'd32768,
              48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF};
        send_pair(p);                                   // widest separation
        p.pjx = 32'sh7FFF_FFFE; p.pjy = 32'sh7FFF_FFFF; p.pjz = 32'sh7FFF_FFFF;
        send_pair(p);                                   // one LSB apart: saturates
        p.qi = 16'sh8000; p.qj = 16'sh8000; p.rep = 48'sh8000_0000_0000;
        p.att = 48'sh8000_0000_0000;
        send_pair(p);
        p.wi = 16'hFFFF; p.wj = 16'hFFFF;
        send_pair(p);                                   // weights above one
        p.wi = 0;
        send_pair(p);
        for (int k = 0; k < 8; k++) begin
            p = '{0, 0, 0, 0, 0, 0, 16'sh1000, 16'shF000, 16'd32768, 16'd32768,
                  48'sh0000_0001_0000, 48'sh0000_0002_0000};
            p.pjx = 32'sh0001_0000 << k;                // x offsets 1 .. 128
            p.pjy = (k[0]) ? -32'sh0000_8000 : 0;
            send_pair(p);
        end
        p.qi = 0; p.rep = 0; p.att = 0;
        send_pair(p);                                   // all terms zero
    endtask

    task automatic drain();
        i_in_valid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 20) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n = 0; i_in_valid = 0; hold_off = 0; burst_left = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_pos_i_x = 0; i_pos_i_y = 0; i_pos_i_z = 0;
        i_pos_j_x = 0; i_pos_j_y = 0; i_pos_j_z = 0;
        i_charge_i = 0; i_charge_j = 0; i_weight_i = 0; i_weight_j = 0;
        i_lj_repulsive = 0; i_lj_attractive = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    apb_write(ADDR_SCALE, 32'hFFFF_FFFF);
                    apb_write(ADDR_ENERGY, 32'd1);
                end
                2: begin
                    apb_write(ADDR_SCALE, 32'd0);
                    apb_write(ADDR_ENERGY, 32'hFFFF_FFFF);
                end
                3: begin
                    apb_write(ADDR_SCALE, $urandom);
                    apb_write(ADDR_ENERGY, 32'd0);
                end
                4: begin
                    apb_write(ADDR_SCALE, 32'd21762127 + $urandom_range(1000));
                    apb_write(ADDR_ENERGY, 32'd1);
                end
                default: ;
            endcase
            if (ph <= 1) directed_pairs();
            if (ph == 1) hold_off = 400;        // back-pressure fills the pipeline
            for (int n = 0; n < RAND_PER_PH; n++) send_pair(rnd_pair());
            drain();
        end
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ljc_pkg.sv
rtl/ljc_recip.sv
rtl/ljc_sqrt.sv
rtl/lj_coulomb_pair_force_core.sv
dv/ljc_pair_checker.sv
dv/tb_top.sv
